@@ rtl/tal_pkg.sv @@
// shared types, constants and tables for the thrust acceleration law block
`timescale 1ns / 1ps
`default_nettype none

package tal_pkg;

    // field widths
    localparam int VEL_W     = 32;
    localparam int MASS_W    = 31;
    localparam int ANG_W     = 31;
    localparam int ACC_W     = 32;
    localparam int THR_W     = 31;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAW_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRUST_LEVEL = 2'd1;

    // thrust laws
    typedef enum logic [MODE_W-1:0] {
        LAW_LEFT     = 3'd0,
        LAW_RIGHT    = 3'd1,
        LAW_PROGRADE = 3'd2,
        LAW_ANTI     = 3'd3,
        LAW_GENERAL  = 3'd4
    } law_t;

    // unit direction: Q2.30
    localparam int FRAC_W = 30;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int SQ_N   = ROOT_W;
    localparam int UD_N   = 31;
    localparam int UD_RW  = ROOT_W + UD_N;
    localparam int U_W    = 32;

    // scaling by thrust over mass
    localparam int MASS_SH = 6;
    localparam int D_W     = MASS_W + MASS_SH;
    localparam int SD_N    = 32;
    localparam int SD_RW   = D_W + SD_N;
    localparam int N2_W    = 64;

    // rotation units
    localparam int XY_W    = 34;
    localparam int Z_W     = 34;
    localparam int CD_N    = 30;
    localparam int TRIG_W  = 32;
    localparam int PROD_W  = 64;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [Z_W-1:0]  HALF_PI     = 34'sd1686629713;
    localparam logic signed [Z_W-1:0]  FULL_PI     = 34'sd3373259426;

    // pipeline stage numbers (stage 1 is loaded at acceptance)
    localparam int U_STG    = 4 + SQ_N + UD_N;
    localparam int SEL_STG  = U_STG + 1;
    localparam int LAST_STG = SEL_STG + 2 + SD_N;
    localparam int ANG_DLY  = U_STG - 5 - CD_N;

    // one result word
    typedef struct packed {
        logic signed [ACC_W-1:0] accel_x;
        logic signed [ACC_W-1:0] accel_y;
        logic signed [ACC_W-1:0] accel_z;
        logic                    fault;
    } res_t;

    // arctangent of 2^-i in Q2.30
    function automatic logic signed [Z_W-1:0] tal_atan(input int i);
        logic signed [Z_W-1:0] a;
        case (i)
            0:       a = 34'sd843314857;
            1:       a = 34'sd497837829;
            2:       a = 34'sd263043837;
            3:       a = 34'sd133525159;
            4:       a = 34'sd67021687;
            5:       a = 34'sd33543516;
            6:       a = 34'sd16775851;
            7:       a = 34'sd8388437;
            8:       a = 34'sd4194283;
            9:       a = 34'sd2097149;
            default: a = (i < CD_N) ? (34'sd1 <<< (30 - i)) : 34'sd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tal_if.sv @@
// valid/ready channel interfaces for sample and result words
`timescale 1ns / 1ps
`default_nettype none

interface tal_in_if;
    import tal_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic [MASS_W-1:0]       mass;
    logic signed [ANG_W-1:0] angle_in_plane;
    logic signed [ANG_W-1:0] angle_out_plane;

    modport source (output valid, vel_x, vel_y, vel_z, mass, angle_in_plane,
                    angle_out_plane, input ready);
    modport sink (input valid, vel_x, vel_y, vel_z, mass, angle_in_plane,
                  angle_out_plane, output ready);
endinterface

interface tal_out_if;
    import tal_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
    logic                    fault;

    modport source (output valid, accel_x, accel_y, accel_z, fault, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, fault, output ready);
endinterface

`default_nettype wire

@@ rtl/tal_delay.sv @@
// enabled shift line that carries side data alongside the cell rows
`timescale 1ns / 1ps
`default_nettype none

module tal_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    // shift one place per enabled cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

`default_nettype wire

@@ rtl/tal_sqrt_cell.sv @@
// one root bit of the pipelined integer square root
`timescale 1ns / 1ps
`default_nettype none

module tal_sqrt_cell
    import tal_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [SQ_W-1:0]   rem_in,
    input  wire logic [ROOT_W-1:0] root_in,
    output logic      [SQ_W-1:0]   rem_out,
    output logic      [ROOT_W-1:0] root_out
);

    localparam int TW = SQ_W + 2;

    logic [TW-1:0]     test;
    logic [SQ_W-1:0]   rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [SQ_W-1:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;

    // trial of (root + 2^step)^2 against the remainder
    always_comb
    begin
        test      = (TW'(root_in) << (STEP + 1)) | (TW'(1) << (2 * STEP));
        rem_next  = rem_in;
        root_next = root_in;
        if (TW'(rem_in) >= test)
        begin
            rem_next  = rem_in - test[SQ_W-1:0];
            root_next = root_in | (ROOT_W'(1) << STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

`default_nettype wire

@@ rtl/tal_div_cell.sv @@
// one quotient bit of a pipelined restoring divider
`timescale 1ns / 1ps
`default_nettype none

module tal_div_cell #(
    parameter int DEN_W = 32,
    parameter int Q_W   = 31,
    parameter int STEP  = 0
) (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [DEN_W+Q_W-1:0]   rem_in,
    input  wire logic [DEN_W-1:0]       den_in,
    input  wire logic [Q_W-1:0]         q_in,
    output logic      [DEN_W+Q_W-1:0]   rem_out,
    output logic      [DEN_W-1:0]       den_out,
    output logic      [Q_W-1:0]         q_out
);

    localparam int RW = DEN_W + Q_W;

    logic [RW-1:0]    sub;
    logic [RW-1:0]    rem_next;
    logic [Q_W-1:0]   q_next;
    logic [RW-1:0]    rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   q_reg;

    // subtract the shifted divisor when it fits
    always_comb
    begin
        sub      = RW'(den_in) << STEP;
        rem_next = rem_in;
        q_next   = q_in;
        if (rem_in >= sub)
        begin
            rem_next = rem_in - sub;
            q_next   = q_in | (Q_W'(1) << STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            q_reg   <= q_next;
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;

endmodule

`default_nettype wire

@@ rtl/tal_cordic_cell.sv @@
// one rotation step of the pipelined sine/cosine unit
`timescale 1ns / 1ps
`default_nettype none

module tal_cordic_cell
    import tal_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic signed [XY_W-1:0] x_in,
    input  wire logic signed [XY_W-1:0] y_in,
    input  wire logic signed [Z_W-1:0]  z_in,
    output logic signed      [XY_W-1:0] x_out,
    output logic signed      [XY_W-1:0] y_out,
    output logic signed      [Z_W-1:0]  z_out
);

    localparam logic signed [Z_W-1:0] ATAN = tal_atan(STEP);

    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;

    // rotate toward zero residual angle, shifts round down
    always_comb
    begin
        if (!z_in[Z_W-1])
        begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

`default_nettype wire

@@ rtl/thrust_acceleration_law_top.sv @@
// Thrust acceleration law. Throughput one word per cycle while no skid word is held;
// each stage of the square root and divider rows is one bit, and each stage of a
// sine/cosine row is one rotation, so nothing iterates in place.
// A two-entry output (register plus skid) lets a word enter while a result waits.
// Reset clears valid flags, law_mode and thrust_level; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module thrust_acceleration_law_top
    import tal_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    tal_in_if.sink                    sample,
    tal_out_if.source                 result
);

    // configuration
    logic [MODE_W-1:0] law_mode_reg;
    logic [THR_W-1:0]  thrust_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            law_mode_reg <= '0;
            thrust_reg   <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_LAW_MODE:     law_mode_reg <= cfg_data[MODE_W-1:0];
                REG_THRUST_LEVEL: thrust_reg   <= cfg_data[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    // pipeline advance and valid line
    logic                en;
    logic                accept;
    logic [LAST_STG-1:0] v_reg;
    logic                skid_valid_reg;
    logic                out_valid_reg;

    assign en           = !skid_valid_reg;
    assign sample.ready = en;
    assign accept       = sample.valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAST_STG-2:0], accept};
        end
    end

    // input decode: magnitudes, signs, special cases
    logic                  is_2d;
    logic                  is_gen;
    logic                  is_bad;
    logic                  vel_zero;
    logic                  mass_zero;
    logic [2:0]            vneg;
    logic [VEL_W-1:0]      mag [3];
    logic [1:0]            flags_in;
    logic [VEL_W-1:0]      mag_reg [3];

    always_comb
    begin
        is_2d     = (law_mode_reg == LAW_LEFT) || (law_mode_reg == LAW_RIGHT);
        is_gen    = law_mode_reg == LAW_GENERAL;
        is_bad    = law_mode_reg > LAW_GENERAL;
        vneg      = {sample.vel_z[VEL_W-1], sample.vel_y[VEL_W-1], sample.vel_x[VEL_W-1]};
        mag[0]    = vneg[0] ? (~sample.vel_x + 1'b1) : sample.vel_x;
        mag[1]    = vneg[1] ? (~sample.vel_y + 1'b1) : sample.vel_y;
        mag[2]    = is_2d ? '0 : (vneg[2] ? (~sample.vel_z + 1'b1) : sample.vel_z);
        vel_zero  = (sample.vel_x == '0) && (sample.vel_y == '0)
                    && (is_2d || (sample.vel_z == '0));
        mass_zero = sample.mass == '0;
        // bit 1: force zero outputs, bit 0: fault
        flags_in[1] = is_bad || mass_zero || (!is_gen && vel_zero);
        flags_in[0] = !is_bad && (mass_zero || (!is_gen && vel_zero));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= mag[i];
            end
        end
    end

    // normalize so the largest magnitude reaches 2^30
    logic [VEL_W-1:0] mag_or;
    logic [4:0]       msb;
    logic [4:0]       sh;
    logic [VEL_W-1:0] w_reg [3];

    always_comb
    begin
        mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];
        msb    = '0;
        for (int i = 0; i < VEL_W; i++)
        begin
            if (mag_or[i])
            begin
                msb = 5'(i);
            end
        end
        sh = (mag_or[31] || mag_or[30]) ? 5'd0 : (5'd30 - msb);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i] <= mag_reg[i] << sh;
            end
        end
    end

    // squares and their sum
    logic [SQ_W-1:0] sq_reg [3];
    logic [SQ_W-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= w_reg[i] * w_reg[i];
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    // square root row
    logic [SQ_W-1:0]   sq_rem  [SQ_N+1];
    logic [ROOT_W-1:0] sq_root [SQ_N+1];

    assign sq_rem[0]  = sum_reg;
    assign sq_root[0] = '0;

    for (genvar j = 0; j < SQ_N; j++)
    begin : g_sqrt
        tal_sqrt_cell #(.STEP(SQ_N - 1 - j)) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (sq_rem[j]),
            .root_in  (sq_root[j]),
            .rem_out  (sq_rem[j+1]),
            .root_out (sq_root[j+1])
        );
    end

    // normalized components wait for the root
    logic [3*VEL_W-1:0] w_d;

    tal_delay #(.WIDTH(3 * VEL_W), .DEPTH(2 + SQ_N)) u_w_dly (
        .clk  (clk),
        .en   (en),
        .din  ({w_reg[2], w_reg[1], w_reg[0]}),
        .dout (w_d)
    );

    // unit components: rows dividing w * 2^30 by the root, rounded
    logic [UD_RW-1:0]  ud_rem [3][UD_N+1];
    logic [ROOT_W-1:0] ud_den [3][UD_N+1];
    logic [UD_N-1:0]   ud_q   [3][UD_N+1];

    for (genvar l = 0; l < 3; l++)
    begin : g_ud_lane
        assign ud_rem[l][0] = UD_RW'({w_d[l*VEL_W +: VEL_W], {FRAC_W{1'b0}}})
                              + UD_RW'(sq_root[SQ_N] >> 1);
        assign ud_den[l][0] = sq_root[SQ_N];
        assign ud_q[l][0]   = '0;
        for (genvar j = 0; j < UD_N; j++)
        begin : g_cell
            tal_div_cell #(.DEN_W(ROOT_W), .Q_W(UD_N), .STEP(UD_N - 1 - j)) u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (ud_rem[l][j]),
                .den_in  (ud_den[l][j]),
                .q_in    (ud_q[l][j]),
                .rem_out (ud_rem[l][j+1]),
                .den_out (ud_den[l][j+1]),
                .q_out   (ud_q[l][j+1])
            );
        end
    end

    // angles wait so the general law lines up with the unit vector
    logic [2*ANG_W-1:0] ang_d;

    tal_delay #(.WIDTH(2 * ANG_W), .DEPTH(1 + ANG_DLY)) u_ang_dly (
        .clk  (clk),
        .en   (en),
        .din  ({sample.angle_out_plane, sample.angle_in_plane}),
        .dout (ang_d)
    );

    // widen to Q2.30 and fold into [-pi/2, pi/2]
    logic signed [Z_W-1:0] z_raw [2];
    logic signed [Z_W-1:0] z_red [2];
    logic [1:0]            flip;
    logic signed [Z_W-1:0] z_reg [2];
    logic [1:0]            flip_reg;

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            z_raw[a] = Z_W'(signed'({ang_d[a*ANG_W +: ANG_W], 2'b00}));
            z_red[a] = z_raw[a];
            flip[a]  = 1'b0;
            if (z_raw[a] > HALF_PI)
            begin
                z_red[a] = z_raw[a] - FULL_PI;
                flip[a]  = 1'b1;
            end
            else if (z_raw[a] < -HALF_PI)
            begin
                z_red[a] = z_raw[a] + FULL_PI;
                flip[a]  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg    <= z_red;
            flip_reg <= flip;
        end
    end

    // rotation rows for alpha and beta
    logic signed [XY_W-1:0] cd_x [2][CD_N+1];
    logic signed [XY_W-1:0] cd_y [2][CD_N+1];
    logic signed [Z_W-1:0]  cd_z [2][CD_N+1];

    for (genvar a = 0; a < 2; a++)
    begin : g_cd_lane
        assign cd_x[a][0] = CORDIC_GAIN;
        assign cd_y[a][0] = '0;
        assign cd_z[a][0] = z_reg[a];
        for (genvar j = 0; j < CD_N; j++)
        begin : g_cell
            tal_cordic_cell #(.STEP(j)) u_cell (
                .clk   (clk),
                .en    (en),
                .x_in  (cd_x[a][j]),
                .y_in  (cd_y[a][j]),
                .z_in  (cd_z[a][j]),
                .x_out (cd_x[a][j+1]),
                .y_out (cd_y[a][j+1]),
                .z_out (cd_z[a][j+1])
            );
        end
    end

    logic [1:0] flip_d;

    tal_delay #(.WIDTH(2), .DEPTH(CD_N)) u_flip_dly (
        .clk  (clk),
        .en   (en),
        .din  (flip_reg),
        .dout (flip_d)
    );

    // undo the fold, then form the direction products
    logic signed [XY_W-1:0]   cos_w [2];
    logic signed [XY_W-1:0]   sin_w [2];
    logic signed [TRIG_W-1:0] cos_reg [2];
    logic signed [TRIG_W-1:0] sin_reg [2];
    logic signed [PROD_W-1:0] pcc_reg;
    logic signed [PROD_W-1:0] pcs_reg;
    logic signed [TRIG_W-1:0] sbp_reg;
    logic signed [PROD_W-1:0] pcc_rnd;
    logic signed [PROD_W-1:0] pcs_rnd;
    logic signed [Z_W-1:0]    gd_reg [3];

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            cos_w[a] = flip_d[a] ? -cd_x[a][CD_N] : cd_x[a][CD_N];
            sin_w[a] = flip_d[a] ? -cd_y[a][CD_N] : cd_y[a][CD_N];
        end
        pcc_rnd = (pcc_reg + (PROD_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        pcs_rnd = (pcs_reg + (PROD_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 2; a++)
            begin
                cos_reg[a] <= cos_w[a][TRIG_W-1:0];
                sin_reg[a] <= sin_w[a][TRIG_W-1:0];
            end
            pcc_reg   <= cos_reg[1] * cos_reg[0];
            pcs_reg   <= cos_reg[1] * sin_reg[0];
            sbp_reg   <= sin_reg[1];
            gd_reg[0] <= pcc_rnd[Z_W-1:0];
            gd_reg[1] <= pcs_rnd[Z_W-1:0];
            gd_reg[2] <= Z_W'(sbp_reg);
        end
    end

    // velocity signs for the law selection
    logic [2:0] vneg_d;

    tal_delay #(.WIDTH(3), .DEPTH(U_STG)) u_vneg_dly (
        .clk  (clk),
        .en   (en),
        .din  (vneg),
        .dout (vneg_d)
    );

    // pick direction magnitude and sign per law
    logic [U_W-1:0]        usel [3];
    logic [2:0]            nsel;
    logic signed [Z_W-1:0] gabs [3];
    logic [U_W-1:0]        usel_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            gabs[i] = gd_reg[i][Z_W-1] ? -gd_reg[i] : gd_reg[i];
            usel[i] = U_W'(ud_q[i][UD_N]);
        end
        nsel = '0;
        case (law_t'(law_mode_reg))
            LAW_LEFT, LAW_RIGHT:
            begin
                usel[0] = U_W'(ud_q[1][UD_N]);
                usel[1] = U_W'(ud_q[0][UD_N]);
                usel[2] = '0;
                nsel[0] = vneg_d[1] != (law_mode_reg != LAW_RIGHT);
                nsel[1] = vneg_d[0] != (law_mode_reg == LAW_RIGHT);
            end
            LAW_PROGRADE, LAW_ANTI:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    nsel[i] = vneg_d[i] != (law_mode_reg == LAW_ANTI);
                end
            end
            LAW_GENERAL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    usel[i] = gabs[i][U_W-1:0];
                    nsel[i] = gd_reg[i][Z_W-1];
                end
            end
            default:
            begin
                nsel = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            usel_reg <= usel;
        end
    end

    // mass lines up with the selected direction
    logic [MASS_W-1:0] mass_d;

    tal_delay #(.WIDTH(MASS_W), .DEPTH(SEL_STG)) u_mass_dly (
        .clk  (clk),
        .en   (en),
        .din  (sample.mass),
        .dout (mass_d)
    );

    // thrust times direction, plus half the divisor for rounding
    logic [N2_W-1:0] prod_reg [3];
    logic [D_W-1:0]  d_reg;
    logic [N2_W-1:0] n2_reg [3];
    logic [D_W-1:0]  dd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= N2_W'(thrust_reg) * N2_W'(usel_reg[i]);
                n2_reg[i]   <= prod_reg[i] + N2_W'(d_reg >> 1);
            end
            d_reg  <= {mass_d, {MASS_SH{1'b0}}};
            dd_reg <= d_reg;
        end
    end

    // quotient beyond 32 bits saturates anyway
    logic [2:0] ovf;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ovf[i] = D_W'(n2_reg[i][N2_W-1:SD_N]) >= dd_reg;
        end
    end

    // scaling division rows
    logic [SD_RW-1:0] sd_rem [3][SD_N+1];
    logic [D_W-1:0]   sd_den [3][SD_N+1];
    logic [SD_N-1:0]  sd_q   [3][SD_N+1];

    for (genvar l = 0; l < 3; l++)
    begin : g_sd_lane
        assign sd_rem[l][0] = SD_RW'(n2_reg[l]);
        assign sd_den[l][0] = dd_reg;
        assign sd_q[l][0]   = '0;
        for (genvar j = 0; j < SD_N; j++)
        begin : g_cell
            tal_div_cell #(.DEN_W(D_W), .Q_W(SD_N), .STEP(SD_N - 1 - j)) u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (sd_rem[l][j]),
                .den_in  (sd_den[l][j]),
                .q_in    (sd_q[l][j]),
                .rem_out (sd_rem[l][j+1]),
                .den_out (sd_den[l][j+1]),
                .q_out   (sd_q[l][j+1])
            );
        end
    end

    // side data for the last stage
    logic [2:0] ovf_d;
    logic [2:0] nsel_d;
    logic [1:0] flags_d;

    tal_delay #(.WIDTH(3), .DEPTH(SD_N)) u_ovf_dly (
        .clk  (clk),
        .en   (en),
        .din  (ovf),
        .dout (ovf_d)
    );

    tal_delay #(.WIDTH(3), .DEPTH(LAST_STG - SEL_STG + 1)) u_nsel_dly (
        .clk  (clk),
        .en   (en),
        .din  (nsel),
        .dout (nsel_d)
    );

    tal_delay #(.WIDTH(2), .DEPTH(LAST_STG)) u_flags_dly (
        .clk  (clk),
        .en   (en),
        .din  (flags_in),
        .dout (flags_d)
    );

    // apply sign and saturate
    function automatic logic signed [ACC_W-1:0] sat_sign(input logic [SD_N-1:0] q,
                                                         input logic ovf_q,
                                                         input logic neg);
        logic [ACC_W-1:0] m;
        if (!neg)
        begin
            m = (ovf_q || q[SD_N-1]) ? {1'b0, {(ACC_W-1){1'b1}}} : ACC_W'(q);
        end
        else
        begin
            m = (ovf_q || (q > {1'b1, {(SD_N-1){1'b0}}})) ? {1'b1, {(ACC_W-1){1'b0}}}
                                                          : ACC_W'(q);
            m = -m;
        end
        return signed'(m);
    endfunction

    res_t res_w;

    always_comb
    begin
        res_w.accel_x = sat_sign(sd_q[0][SD_N], ovf_d[0], nsel_d[0]);
        res_w.accel_y = sat_sign(sd_q[1][SD_N], ovf_d[1], nsel_d[1]);
        res_w.accel_z = sat_sign(sd_q[2][SD_N], ovf_d[2], nsel_d[2]);
        res_w.fault   = flags_d[0];
        if (flags_d[1])
        begin
            res_w.accel_x = '0;
            res_w.accel_y = '0;
            res_w.accel_z = '0;
        end
    end

    // output register with skid word
    logic produce;
    res_t out_reg;
    res_t skid_reg;

    assign produce = v_reg[LAST_STG-1] && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && result.ready)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= produce;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= produce;
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && result.ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_w;
        end
        else if (!out_valid_reg)
        begin
            out_reg <= res_w;
        end
        else if (produce)
        begin
            skid_reg <= res_w;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.accel_x = out_reg.accel_x;
    assign result.accel_y = out_reg.accel_y;
    assign result.accel_z = out_reg.accel_z;
    assign result.fault   = out_reg.fault;

`ifndef NO_ASSERTIONS
    // the skid word is only ever behind a held output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // the skid fills only when the output word was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result.ready))
        else $error("skid filled while output was free");

    // a fault word carries zero acceleration
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.fault) |->
        (result.accel_x == '0 && result.accel_y == '0 && result.accel_z == '0))
        else $error("fault word with nonzero acceleration");

    // an undefined law gives zero and no fault
    a_bad_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && law_mode_reg > LAW_GENERAL) |->
        (!result.fault && result.accel_x == '0 && result.accel_y == '0
         && result.accel_z == '0))
        else $error("undefined law gave a nonzero word");
`endif

endmodule

`default_nettype wire
